FILE: rtl/scba_pkg.sv
// shared types, constants and volume tables for the sound command byte assembler
package scba_pkg;

   // history length in bytes, newest byte included
   localparam int HISTORY_DEPTH = 4;
   // stored history entries: the newest byte is the incoming one
   localparam int HIST_REGS = HISTORY_DEPTH - 1;
   localparam int HIST_WIDTH = 9;
   // empty history mark, never equal to a real byte
   localparam logic [HIST_WIDTH-1:0] EMPTY_MARK = 9'h100;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GENERATION_MODE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROM_CONTROLS_VOLUME = 1'd1;

   // volume scale
   localparam logic [15:0] VOL_FULL = 16'h8000;
   localparam logic [63:0] VOL_RATIO = ((64'd981201 << 32) + 64'd500000) / 64'd1000000;

   // protocol bytes
   localparam logic [7:0] DCS_LEAD = 8'h55;
   localparam logic [7:0] DCS_VOLUME = 8'hAA;
   localparam logic [7:0] DMD_VOLUME = 8'h79;
   localparam logic [7:0] DMD_PREFIX = 8'h7A;
   localparam logic [7:0] WS_PREFIX = 8'hFE;
   localparam logic [7:0] WS_PAIR_MASK = 8'hFC;
   localparam logic [7:0] WS_VOL_TOP = 8'h2F;

   // stop-music codes
   localparam logic [15:0] DCS_STOP = 16'h03E3;
   localparam logic [15:0] DE_STOP_A = 16'h0018;
   localparam logic [15:0] DE_STOP_B = 16'h0023;
   localparam logic [15:0] WS_STOP_MASK = 16'hF0FF;
   localparam logic [15:0] WS_STOP_CODE = 16'hF000;

   typedef enum logic [2:0] {
      MODE_NONE      = 3'd0,
      MODE_DCS       = 3'd1,
      MODE_DMD       = 3'd2,
      MODE_S11       = 3'd3,
      MODE_DE        = 3'd4,
      MODE_DE_DMD32  = 3'd5,
      MODE_WS        = 3'd6,
      MODE_GTS80A    = 3'd7
   } mode_type;

   // configuration seen by the decoder
   typedef struct packed {
      mode_type mode;
      logic     rom_volume;
   } cfg_type;

   // one result transaction
   typedef struct packed {
      logic        command_valid;
      logic [15:0] command_word;
      logic        stop_music;
      logic        volume_valid;
      logic [15:0] volume_level;
      logic        byte_filtered;
   } result_type;

   typedef logic [15:0] vol_table_type [256];
   typedef logic [15:0] ws_table_type [32];

   // dcs volume: 4 * ratio^(255-v) in Q2.30, rounded to Q1.15, saturated
   function automatic vol_table_type dcs_table_calc();
      vol_table_type t;
      logic [63:0] acc;
      logic [63:0] lvl;
      for (int v = 0; v < 256; v++) begin
         if (v == 0) begin
            t[v] = 16'd0;
         end else begin
            acc = 64'd1 << 32;
            for (int k = 0; k < 255 - v; k++) begin
               acc = (acc * VOL_RATIO + (64'd1 << 31)) >> 32;
            end
            lvl = (acc + (64'd1 << 14)) >> 15;
            t[v] = (lvl > 64'd32768) ? VOL_FULL : lvl[15:0];
         end
      end
      return t;
   endfunction

   // dmd volume: linear over 0..127
   function automatic vol_table_type dmd_table_calc();
      vol_table_type t;
      logic [31:0] q;
      for (int v = 0; v < 256; v++) begin
         q = (32'(v) * 32'd32768 + 32'd63) / 32'd127;
         t[v] = (v >= 127) ? VOL_FULL : q[15:0];
      end
      return t;
   endfunction

   // ws volume: index is 0x2f minus the byte
   function automatic ws_table_type ws_table_calc();
      ws_table_type t;
      logic [31:0] q;
      for (int k = 0; k < 32; k++) begin
         q = (32'(k) * 32'd32768 + 32'd15) / 32'd31;
         t[k] = q[15:0];
      end
      return t;
   endfunction

   localparam vol_table_type DCS_VOL_TABLE = dcs_table_calc();
   localparam vol_table_type DMD_VOL_TABLE = dmd_table_calc();
   localparam ws_table_type WS_VOL_TABLE = ws_table_calc();

endpackage

FILE: rtl/sound_command_byte_assembler_core.sv
// top level: input register, rule decode and result register
// The block takes one sound-latch byte per transaction and returns one result
// per byte: an assembled 16-bit command with its stop-music flag, a volume
// update and a filter indication, under the rules of the configured generation
// mode. It accepts a byte every clock cycle unless a stalled result holds the
// input register. A byte is accepted into the input register, then one decode
// pass loads its result into the result register, which holds it while
// rsp_stall is high. The rule decode updates the byte history and pairing
// state in that single pass, which sets the one-byte-per-cycle rate when no
// stall holds. The user must write configuration registers only while no byte
// is in flight; the block itself does not enforce this.
module sound_command_byte_assembler_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_sound_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_command_valid,
   output logic [15:0]                           rsp_command_word,
   output logic                                  rsp_stop_music,
   output logic                                  rsp_volume_valid,
   output logic [15:0]                           rsp_volume_level,
   output logic                                  rsp_byte_filtered,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [scba_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [scba_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   scba_pkg::cfg_type    cfg;
   scba_pkg::result_type result;

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   scba_pkg::result_type out_ff;
   logic                 out_open;
   logic                 advance;

   scba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   scba_rules u_rules (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (advance),
      .sound_byte (in_byte_ff),
      .result     (result)
   );

   // pipeline flow control
   assign out_open = ~out_valid_ff | ~rsp_stall;
   assign advance = in_valid_ff & out_open;
   assign req_stall = in_valid_ff & ~out_open;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = out_open ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_sound_byte;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   // result transaction
   assign rsp_valid = out_valid_ff;
   assign rsp_command_valid = out_ff.command_valid;
   assign rsp_command_word = out_ff.command_word;
   assign rsp_stop_music = out_ff.stop_music;
   assign rsp_volume_valid = out_ff.volume_valid;
   assign rsp_volume_level = out_ff.volume_level;
   assign rsp_byte_filtered = out_ff.byte_filtered;

endmodule

FILE: rtl/scba_csr.sv
// configuration registers: generation mode and rom volume enable
module scba_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [scba_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [scba_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output scba_pkg::cfg_type                     cfg
);

   scba_pkg::mode_type mode_ff;
   scba_pkg::mode_type mode_in;
   logic               rom_volume_ff;
   logic               rom_volume_in;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      mode_in = mode_ff;
      rom_volume_in = rom_volume_ff;
      if (csr_valid) begin
         unique case (csr_index)
            scba_pkg::CSR_GENERATION_MODE: mode_in = scba_pkg::mode_type'(csr_data);
            scba_pkg::CSR_ROM_CONTROLS_VOLUME: rom_volume_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= scba_pkg::MODE_NONE;
         rom_volume_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         rom_volume_ff <= rom_volume_in;
      end
   end

   assign cfg.mode = mode_ff;
   assign cfg.rom_volume = rom_volume_ff;

endmodule

FILE: rtl/scba_rules.sv
// byte history, pairing state and per-mode rule decode for one byte
module scba_rules (
   input  logic                   clock,
   input  logic                   reset,
   input  scba_pkg::cfg_type      cfg,
   input  logic                   step,
   input  logic [7:0]             sound_byte,
   output scba_pkg::result_type   result
);

   logic [scba_pkg::HIST_WIDTH-1:0] hist_ff [scba_pkg::HIST_REGS];
   logic [scba_pkg::HIST_WIDTH-1:0] hist_in [scba_pkg::HIST_REGS];
   logic                            phase_ff;
   logic                            phase_in;
   logic [7:0]                      pending_ff;
   logic [7:0]                      pending_in;
   logic                            filter_ff;
   logic                            filter_in;

   logic [scba_pkg::HIST_WIDTH-1:0] cur;
   logic [scba_pkg::HIST_WIDTH-1:0] h1;
   logic [scba_pkg::HIST_WIDTH-1:0] h2;
   logic [scba_pkg::HIST_WIDTH-1:0] h3;
   logic                            cmp;
   logic                            clear_hist;
   logic                            vol_ok;
   logic [15:0]                     vol;
   logic [7:0]                      ws_idx;
   logic [15:0]                     word;
   logic                            stop;

   assign cur = {1'b0, sound_byte};
   assign h1 = hist_ff[0];
   assign h2 = hist_ff[1];
   assign h3 = hist_ff[2];
   // complement guard: previous byte is the inverse of this one
   assign cmp = (h1 == {1'b0, ~sound_byte});
   assign ws_idx = scba_pkg::WS_VOL_TOP - sound_byte;

   // mode rules on phase, pending byte, filter flag and history
   always_comb begin
      phase_in = ~phase_ff;
      pending_in = pending_ff;
      filter_in = filter_ff;
      clear_hist = 1'b0;
      vol_ok = 1'b0;
      vol = 16'd0;
      unique case (cfg.mode)
         scba_pkg::MODE_DCS: begin
            filter_in = 1'b0;
            if (h3 == {1'b0, scba_pkg::DCS_LEAD}) begin
               if ((h2 >= 9'h0AB && h2 <= 9'h0B0 && cmp) ||
                   (h2 == 9'h0C2 || h2 == 9'h0C3) ||
                   (h2 >= 9'h0BA && h2 <= 9'h0C1 && cmp) ||
                   (h2 == {1'b0, scba_pkg::DCS_VOLUME})) begin
                  clear_hist = 1'b1;
                  phase_in = 1'b0;
                  filter_in = 1'b1;
               end
               if (h2 == {1'b0, scba_pkg::DCS_VOLUME} && cmp && cfg.rom_volume) begin
                  vol_ok = 1'b1;
                  vol = scba_pkg::DCS_VOL_TABLE[h1[7:0]];
               end
            end
         end
         scba_pkg::MODE_DMD: begin
            filter_in = 1'b0;
            if (h2 == {1'b0, scba_pkg::DMD_VOLUME} && cmp) begin
               if (cfg.rom_volume) begin
                  vol_ok = 1'b1;
                  vol = scba_pkg::DMD_VOL_TABLE[h1[7:0]];
               end
               clear_hist = 1'b1;
               phase_in = 1'b0;
               filter_in = 1'b1;
            end else if (h1 == {1'b0, scba_pkg::DMD_PREFIX}) begin
               pending_in = scba_pkg::DMD_PREFIX;
               phase_in = 1'b0;
            end else if (sound_byte != scba_pkg::DMD_PREFIX) begin
               pending_in = 8'h00;
               phase_in = 1'b0;
            end else begin
               phase_in = 1'b1;
            end
         end
         scba_pkg::MODE_S11: begin
            if (cur != h1) begin
               pending_in = 8'h00;
               phase_in = 1'b0;
            end else begin
               phase_in = 1'b1;
            end
         end
         scba_pkg::MODE_DE, scba_pkg::MODE_DE_DMD32: begin
            if ((sound_byte != 8'hFF && sound_byte != 8'h00) ||
                (h1 == 9'h000 && sound_byte == 8'h00)) begin
               pending_in = 8'h00;
               phase_in = 1'b0;
            end else begin
               phase_in = 1'b1;
            end
         end
         scba_pkg::MODE_WS: begin
            filter_in = 1'b0;
            if (h1 == {1'b0, scba_pkg::WS_PREFIX}) begin
               if (sound_byte >= 8'h10 && sound_byte <= 8'h2F) begin
                  if (cfg.rom_volume) begin
                     vol_ok = 1'b1;
                     vol = scba_pkg::WS_VOL_TABLE[ws_idx[4:0]];
                  end
                  clear_hist = 1'b1;
                  phase_in = 1'b0;
                  filter_in = 1'b1;
               end else if (sound_byte >= 8'h01 && sound_byte <= 8'h0F) begin
                  pending_in = 8'h00;
                  phase_in = 1'b0;
                  filter_in = 1'b1;
               end
            end
            if ((sound_byte & scba_pkg::WS_PAIR_MASK) == scba_pkg::WS_PAIR_MASK) begin
               phase_in = 1'b1;
            end
         end
         scba_pkg::MODE_GTS80A: begin
            pending_in = 8'h00;
            phase_in = 1'b0;
            filter_in = (sound_byte == 8'h00);
         end
         default: ;
      endcase
      // swallowed or first half: byte becomes the pending high byte
      word = {pending_in, sound_byte};
      if (filter_in || phase_in) begin
         pending_in = sound_byte;
      end
   end

   // stop-music codes per mode
   always_comb begin
      unique case (cfg.mode)
         scba_pkg::MODE_DCS: stop = (word == scba_pkg::DCS_STOP);
         scba_pkg::MODE_DE_DMD32: stop = (word == scba_pkg::DE_STOP_A) ||
                                         (word == scba_pkg::DE_STOP_B);
         scba_pkg::MODE_WS: stop = (word == 16'h0000) ||
                                   ((word & scba_pkg::WS_STOP_MASK) == scba_pkg::WS_STOP_CODE);
         default: stop = 1'b0;
      endcase
   end

   // history shift or clear
   always_comb begin
      for (int i = 0; i < scba_pkg::HIST_REGS; i++) begin
         if (clear_hist) begin
            hist_in[i] = scba_pkg::EMPTY_MARK;
         end else if (i == 0) begin
            hist_in[i] = cur;
         end else begin
            hist_in[i] = hist_ff[i-1];
         end
      end
   end

   // result of this byte
   always_comb begin
      result.command_valid = ~(filter_in | phase_in);
      result.command_word = (filter_in | phase_in) ? 16'd0 : word;
      result.stop_music = ~(filter_in | phase_in) & stop;
      result.volume_valid = vol_ok;
      result.volume_level = vol_ok ? vol : 16'd0;
      result.byte_filtered = filter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < scba_pkg::HIST_REGS; i++) begin
            hist_ff[i] <= scba_pkg::EMPTY_MARK;
         end
         phase_ff <= 1'b0;
         pending_ff <= 8'hFF;
         filter_ff <= 1'b0;
      end else if (step) begin
         hist_ff <= hist_in;
         phase_ff <= phase_in;
         pending_ff <= pending_in;
         filter_ff <= filter_in;
      end
   end

endmodule
